@@ sv/merf_pkg.sv @@
// Shared types and constants for the MIDI event redundancy filter.
// Used by merf_store and midi_event_redundancy_filter; no dependencies.
`default_nettype none
package merf_pkg;

    localparam int LAST_TRACK_DEF = 63;
    localparam int COUNT_BITS_DEF = 32;
    localparam int SLOT_DEPTH     = 2048;
    localparam int SLOT_BITS      = 11;

    localparam logic [6:0] CTRL_SKIP_NUM = 7'h54;
    localparam logic [3:0] CTRL_SKIP_CH  = 4'd9;
    localparam logic [7:0] NOTES_MAX     = 8'd128;

    typedef enum logic [3:0] {
        EV_META     = 4'd0,
        EV_NOTE_ON  = 4'd1,
        EV_NOTE_OFF = 4'd2,
        EV_CTRL     = 4'd3,
        EV_PROG     = 4'd4,
        EV_CHPRES   = 4'd5,
        EV_KEYPRES  = 4'd6,
        EV_BEND     = 4'd7,
        EV_SYSEX_F0 = 4'd8,
        EV_SYSEX_F7 = 4'd9,
        EV_OTHER    = 4'd10
    } event_kind_t;

    typedef enum logic [2:0] {
        MK_SEQNUM  = 3'd0,
        MK_OFFSET  = 3'd1,
        MK_TEMPO   = 3'd2,
        MK_TIMESIG = 3'd3,
        MK_MARKER  = 3'd4,
        MK_NAME    = 3'd5,
        MK_END     = 3'd6,
        MK_OTHER   = 3'd7
    } meta_kind_t;

    typedef enum logic [2:0] {
        VD_DISCARD     = 3'd0,
        VD_KEEP        = 3'd1,
        VD_FIRST_BEGIN = 3'd2,
        VD_FIRST_TRACK = 3'd3,
        VD_TRACK_BEGIN = 3'd4,
        VD_TRACK_END   = 3'd5
    } verdict_t;

    typedef struct packed {
        logic        event_ok;
        logic [15:0] track;
        logic [3:0]  event_kind;
        logic [2:0]  meta_kind;
        logic [3:0]  channel;
        logic [6:0]  data_first;
        logic [6:0]  data_second;
        logic [31:0] meta_value;
    } in_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [31:0] track_event_count;
        logic [31:0] track_note_count;
        logic [15:0] track_channel_mask;
        logic [15:0] overall_channel_mask;
        logic [31:0] tempo_change_count;
        logic [31:0] timesig_change_count;
        logic [31:0] marker_total;
        logic [31:0] last_tempo_value;
        logic [31:0] last_timesig_value;
        logic [7:0]  notes_sounding;
    } out_t;

    // one entry per (channel, note/controller); all-zero is the reset value
    typedef struct packed {
        logic       note_on;
        logic       ctrl_valid;
        logic [6:0] ctrl_val;
    } slot_word_t;

    // program memory entry, valid clear means no value
    typedef struct packed {
        logic       valid;
        logic [6:0] val;
    } prog_word_t;

endpackage
`default_nettype wire

@@ sv/merf_store.sv @@
// Note/controller slot memory and per-track statistics memory, with the
// clearing sweep after reset. Depends on merf_pkg.
`default_nettype none
module merf_store #(
    parameter int LAST_TRACK = merf_pkg::LAST_TRACK_DEF,
    parameter int COUNT_BITS = merf_pkg::COUNT_BITS_DEF,
    localparam int TRK_BITS  = (LAST_TRACK + 1 < 2) ? 1 : $clog2(LAST_TRACK + 1)
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  rd_en,
    input  wire  [merf_pkg::SLOT_BITS-1:0]       rd_slot,
    input  wire  [TRK_BITS-1:0]                  rd_trk,
    output merf_pkg::slot_word_t                 slot_q,
    output logic [COUNT_BITS-1:0]                trk_events_q,
    output logic [COUNT_BITS-1:0]                trk_notes_q,
    output logic [15:0]                          trk_mask_q,
    output logic                                 trk_name_q,
    output logic                                 trk_end_q,
    input  wire                                  wr_en,
    input  wire  [merf_pkg::SLOT_BITS-1:0]       wr_slot,
    input  wire  [TRK_BITS-1:0]                  wr_trk,
    input  merf_pkg::slot_word_t                 slot_d,
    input  wire                                  trk_wr_en,
    input  wire  [COUNT_BITS-1:0]                trk_events_d,
    input  wire  [COUNT_BITS-1:0]                trk_notes_d,
    input  wire  [15:0]                          trk_mask_d,
    input  wire                                  trk_name_d,
    input  wire                                  trk_end_d,
    output logic                                 clear_done
);
    localparam int NTRK     = LAST_TRACK + 1;
    localparam int TW       = 2 * COUNT_BITS + 18;
    localparam int CLR_BITS = merf_pkg::SLOT_BITS + 1;

    merf_pkg::slot_word_t slot_mem [merf_pkg::SLOT_DEPTH];
    logic [TW-1:0]        trk_mem  [NTRK];
    logic [TW-1:0]        trk_rd;

    logic [CLR_BITS-1:0] clr_reg;
    logic [CLR_BITS-1:0] clr_next;
    logic                trk_clr;

    assign clear_done = clr_reg[CLR_BITS-1];
    assign trk_clr    = !clear_done && (clr_reg < CLR_BITS'(NTRK));
    assign clr_next   = clear_done ? clr_reg : clr_reg + CLR_BITS'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else begin
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!clear_done) begin
            slot_mem[clr_reg[merf_pkg::SLOT_BITS-1:0]] <= '0;
        end else if (wr_en) begin
            slot_mem[wr_slot] <= slot_d;
        end
        if (rd_en) begin
            slot_q <= slot_mem[rd_slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (trk_clr) begin
            trk_mem[clr_reg[TRK_BITS-1:0]] <= '0;
        end else if (clear_done && trk_wr_en) begin
            trk_mem[wr_trk] <= {trk_events_d, trk_notes_d, trk_mask_d, trk_name_d, trk_end_d};
        end
        if (rd_en) begin
            trk_rd <= trk_mem[rd_trk];
        end
    end

    assign {trk_events_q, trk_notes_q, trk_mask_q, trk_name_q, trk_end_q} = trk_rd;

endmodule
`default_nettype wire

@@ sv/midi_event_redundancy_filter.sv @@
// MIDI event redundancy filter top level: request capture, decision logic,
// small state registers and result register. Depends on merf_pkg, merf_store.
// Result path: the request and its slot/track memory read are registered in
// stage 1, then the decision goes into the result register; a held result
// stalls stage 1. Each request does a slot/track memory read, then modify and
// write back; one request is in flight at a time.
// Reset: aresetn synchronous active low; afterwards a sweep over the 2048 slot
// entries clears the slot and track memories while s_ready stays low.
`default_nettype none
module midi_event_redundancy_filter #(
    parameter int LAST_TRACK = merf_pkg::LAST_TRACK_DEF,
    parameter int COUNT_BITS = merf_pkg::COUNT_BITS_DEF
) (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            cfg_wr_en,
    input  wire            cfg_wr_data,
    input  wire            s_valid,
    output logic           s_ready,
    input  merf_pkg::in_t  s_data,
    output logic           m_valid,
    input  wire            m_ready,
    output merf_pkg::out_t m_data
);
    localparam int NTRK     = LAST_TRACK + 1;
    localparam int TRK_BITS = (NTRK < 2) ? 1 : $clog2(NTRK);
    localparam int CB       = COUNT_BITS;

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
        sat_inc = (v == '1) ? v : v + CB'(1);
    endfunction

    merf_pkg::in_t        item_reg;
    logic                 s1_valid_reg;
    logic                 m_valid_reg;
    merf_pkg::out_t       out_reg;
    logic                 rec_reg;

    merf_pkg::prog_word_t prog_reg  [16];
    logic [7:0]           notes_reg [16];
    logic [31:0]          tempo_last_reg, tempo_last_next;
    logic [31:0]          ts_last_reg, ts_last_next;
    logic                 seq_seen_reg, seq_seen_next;
    logic                 off_seen_reg, off_seen_next;
    logic [15:0]          chall_reg, chall_next;
    logic [CB-1:0]        tempo_cnt_reg, tempo_cnt_next;
    logic [CB-1:0]        ts_cnt_reg, ts_cnt_next;
    logic [CB-1:0]        mark_cnt_reg, mark_cnt_next;
    merf_pkg::prog_word_t prog_next;
    logic [7:0]           notes_next;

    merf_pkg::slot_word_t slot_q, slot_next;
    logic [CB-1:0]        trk_events_q, trk_notes_q, trk_events_next, trk_notes_next;
    logic [15:0]          trk_mask_q, trk_mask_next;
    logic                 trk_name_q, trk_end_q, trk_name_next, trk_end_next;
    logic                 clear_done;

    logic                 accept, s1_fire, in_range, trk_ok, chan_kept;
    merf_pkg::verdict_t   verdict;
    logic [3:0]           ch;

    assign s_ready = clear_done && !s1_valid_reg;
    assign accept  = s_valid && s_ready;
    assign s1_fire = s1_valid_reg && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
    assign ch      = item_reg.channel;

    merf_store #(
        .LAST_TRACK(LAST_TRACK),
        .COUNT_BITS(COUNT_BITS)
    ) u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rd_en       (accept),
        .rd_slot     ({s_data.channel, s_data.data_first}),
        .rd_trk      (s_data.track[TRK_BITS-1:0]),
        .slot_q      (slot_q),
        .trk_events_q(trk_events_q),
        .trk_notes_q (trk_notes_q),
        .trk_mask_q  (trk_mask_q),
        .trk_name_q  (trk_name_q),
        .trk_end_q   (trk_end_q),
        .wr_en       (s1_fire && in_range),
        .wr_slot     ({item_reg.channel, item_reg.data_first}),
        .wr_trk      (item_reg.track[TRK_BITS-1:0]),
        .slot_d      (slot_next),
        .trk_wr_en   (s1_fire && in_range),
        .trk_events_d(trk_events_next),
        .trk_notes_d (trk_notes_next),
        .trk_mask_d  (trk_mask_next),
        .trk_name_d  (trk_name_next),
        .trk_end_d   (trk_end_next),
        .clear_done  (clear_done)
    );

    // track stats are reported for any in-range track, even on an invalid event
    assign trk_ok   = item_reg.track <= 16'(LAST_TRACK);
    assign in_range = item_reg.event_ok && trk_ok;

    // decision and state update for the request held in stage 1
    always_comb begin
        verdict         = merf_pkg::VD_DISCARD;
        chan_kept       = 1'b0;
        slot_next       = slot_q;
        trk_events_next = trk_events_q;
        trk_notes_next  = trk_notes_q;
        trk_mask_next   = trk_mask_q;
        trk_name_next   = trk_name_q;
        trk_end_next    = trk_end_q;
        prog_next       = prog_reg[ch];
        notes_next      = notes_reg[ch];
        tempo_last_next = tempo_last_reg;
        ts_last_next    = ts_last_reg;
        seq_seen_next   = seq_seen_reg;
        off_seen_next   = off_seen_reg;
        chall_next      = chall_reg;
        tempo_cnt_next  = tempo_cnt_reg;
        ts_cnt_next     = ts_cnt_reg;
        mark_cnt_next   = mark_cnt_reg;
        if (in_range) begin
            case (item_reg.event_kind)
                merf_pkg::EV_META: begin
                    case (item_reg.meta_kind)
                        merf_pkg::MK_SEQNUM: begin
                            if (rec_reg && !seq_seen_reg) begin
                                seq_seen_next = 1'b1;
                                verdict       = merf_pkg::VD_FIRST_BEGIN;
                            end
                        end
                        merf_pkg::MK_OFFSET: begin
                            if (rec_reg && !off_seen_reg) begin
                                off_seen_next = 1'b1;
                                verdict       = merf_pkg::VD_FIRST_BEGIN;
                            end
                        end
                        merf_pkg::MK_TEMPO: begin
                            if (item_reg.meta_value != tempo_last_reg) begin
                                if (rec_reg) tempo_cnt_next = sat_inc(tempo_cnt_reg);
                                tempo_last_next = item_reg.meta_value;
                                verdict         = merf_pkg::VD_FIRST_TRACK;
                            end
                        end
                        merf_pkg::MK_TIMESIG: begin
                            if (item_reg.meta_value != ts_last_reg) begin
                                if (rec_reg) ts_cnt_next = sat_inc(ts_cnt_reg);
                                ts_last_next = item_reg.meta_value;
                                verdict      = merf_pkg::VD_FIRST_TRACK;
                            end
                        end
                        merf_pkg::MK_MARKER: begin
                            if (rec_reg) mark_cnt_next = sat_inc(mark_cnt_reg);
                            verdict = merf_pkg::VD_FIRST_TRACK;
                        end
                        merf_pkg::MK_NAME: begin
                            if (rec_reg && !trk_name_q) begin
                                trk_name_next = 1'b1;
                                verdict       = merf_pkg::VD_TRACK_BEGIN;
                            end
                        end
                        merf_pkg::MK_END: begin
                            if (rec_reg && !trk_end_q) begin
                                trk_end_next = 1'b1;
                                verdict      = merf_pkg::VD_TRACK_END;
                            end
                        end
                        default: ;
                    endcase
                end
                merf_pkg::EV_NOTE_ON: begin
                    if (!slot_q.note_on) begin
                        if (rec_reg) trk_notes_next = sat_inc(trk_notes_q);
                        slot_next.note_on = 1'b1;
                        if (notes_reg[ch] < merf_pkg::NOTES_MAX) notes_next = notes_reg[ch] + 8'd1;
                        chan_kept = 1'b1;
                    end
                end
                merf_pkg::EV_NOTE_OFF: begin
                    if (slot_q.note_on) begin
                        slot_next.note_on = 1'b0;
                        if (notes_reg[ch] != 8'd0) notes_next = notes_reg[ch] - 8'd1;
                        chan_kept = 1'b1;
                    end
                end
                merf_pkg::EV_CTRL: begin
                    if (!(item_reg.data_first == merf_pkg::CTRL_SKIP_NUM
                          && ch == merf_pkg::CTRL_SKIP_CH)
                        && !(slot_q.ctrl_valid && slot_q.ctrl_val == item_reg.data_second)) begin
                        slot_next.ctrl_valid = 1'b1;
                        slot_next.ctrl_val   = item_reg.data_second;
                        chan_kept            = 1'b1;
                    end
                end
                merf_pkg::EV_PROG: begin
                    if (!(prog_reg[ch].valid && prog_reg[ch].val == item_reg.data_first)) begin
                        prog_next = '{valid: 1'b1, val: item_reg.data_first};
                        chan_kept = 1'b1;
                    end
                end
                merf_pkg::EV_CHPRES, merf_pkg::EV_KEYPRES, merf_pkg::EV_BEND: begin
                    chan_kept = 1'b1;
                end
                merf_pkg::EV_SYSEX_F0, merf_pkg::EV_SYSEX_F7: begin
                    verdict = merf_pkg::VD_KEEP;
                end
                default: ;
            endcase
            if (chan_kept) begin
                verdict = merf_pkg::VD_KEEP;
                if (rec_reg) begin
                    trk_events_next = sat_inc(trk_events_q);
                    trk_mask_next   = trk_mask_q | (16'd1 << ch);
                    chall_next      = chall_reg | trk_mask_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            rec_reg      <= 1'b1;
            tempo_last_reg <= '0;
            ts_last_reg    <= '0;
            seq_seen_reg   <= 1'b0;
            off_seen_reg   <= 1'b0;
            chall_reg      <= '0;
            tempo_cnt_reg  <= '0;
            ts_cnt_reg     <= '0;
            mark_cnt_reg   <= '0;
            for (int i = 0; i < 16; i++) begin
                prog_reg[i]  <= '0;
                notes_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) rec_reg <= cfg_wr_data;
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                tempo_last_reg <= tempo_last_next;
                ts_last_reg    <= ts_last_next;
                seq_seen_reg   <= seq_seen_next;
                off_seen_reg   <= off_seen_next;
                chall_reg      <= chall_next;
                tempo_cnt_reg  <= tempo_cnt_next;
                ts_cnt_reg     <= ts_cnt_next;
                mark_cnt_reg   <= mark_cnt_next;
                prog_reg[ch]   <= prog_next;
                notes_reg[ch]  <= notes_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) item_reg <= s_data;
        if (s1_fire) begin
            out_reg.verdict              <= verdict;
            out_reg.track_event_count    <= trk_ok ? 32'(trk_events_next) : 32'd0;
            out_reg.track_note_count     <= trk_ok ? 32'(trk_notes_next) : 32'd0;
            out_reg.track_channel_mask   <= trk_ok ? trk_mask_next : 16'd0;
            out_reg.overall_channel_mask <= chall_next;
            out_reg.tempo_change_count   <= 32'(tempo_cnt_next);
            out_reg.timesig_change_count <= 32'(ts_cnt_next);
            out_reg.marker_total         <= 32'(mark_cnt_next);
            out_reg.last_tempo_value     <= tempo_last_next;
            out_reg.last_timesig_value   <= ts_last_next;
            out_reg.notes_sounding       <= notes_next;
        end
    end

    a_no_accept_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        !clear_done |-> !s_ready) else $error("request taken during memory clear");
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> !s_ready) else $error("second request while one in flight");
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg) else $error("accepted request lost");
    a_fire_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_fire |=> m_valid_reg) else $error("result not presented");
    a_notes_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> notes_reg[ch] <= merf_pkg::NOTES_MAX)
        else $error("sounding note count above limit");

endmodule
`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for midi_event_redundancy_filter: directed and random MIDI
// events through the valid/ready channels, results checked against an in-bench predictor.
// Depends on merf_pkg and the filter RTL.
`default_nettype none
module tb;

    localparam int NTRK = 64;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_wr_data = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    merf_pkg::in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    merf_pkg::out_t m_data;

    midi_event_redundancy_filter uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    // predictor state
    bit          note_map [2048];
    logic [7:0]  ctrl_last [2048];
    logic [7:0]  prog_last [16];
    logic [7:0]  notes_on [16];
    logic [31:0] tempo_last, timesig_last;
    bit          seqnum_seen, offset_seen;
    bit          name_seen [NTRK];
    bit          end_seen [NTRK];
    logic [31:0] trk_events [NTRK];
    logic [31:0] trk_notes [NTRK];
    logic [15:0] trk_chans [NTRK];
    logic [15:0] chans_all;
    logic [31:0] tempo_cnt, timesig_cnt, marker_cnt;
    bit          recording;

    merf_pkg::out_t verdict_queue [$];
    int   errors = 0;
    int   sent = 0;
    int   checked = 0;
    int   hold_cycles = 0;
    bit   stall_en = 1'b1;

    function automatic logic [31:0] bump(logic [31:0] v);
        return (v == CNT_MAX) ? v : v + 1;
    endfunction

    task automatic clear_model();
        for (int i = 0; i < 2048; i++) begin
            note_map[i] = 0;
            ctrl_last[i] = 8'hFF;
        end
        for (int i = 0; i < 16; i++) begin
            prog_last[i] = 8'hFF;
            notes_on[i] = 0;
        end
        for (int i = 0; i < NTRK; i++) begin
            name_seen[i] = 0;
            end_seen[i] = 0;
            trk_events[i] = 0;
            trk_notes[i] = 0;
            trk_chans[i] = 0;
        end
        tempo_last = 0;
        timesig_last = 0;
        seqnum_seen = 0;
        offset_seen = 0;
        chans_all = 0;
        tempo_cnt = 0;
        timesig_cnt = 0;
        marker_cnt = 0;
        recording = 1;
    endtask

    function automatic merf_pkg::verdict_t judge_event(merf_pkg::in_t ev);
        logic [10:0] slot;
        int t;
        slot = {ev.channel, ev.data_first};
        t = int'(ev.track);
        if (!ev.event_ok || ev.track > NTRK - 1) return merf_pkg::VD_DISCARD;
        case (ev.event_kind)
            merf_pkg::EV_META: begin
                case (ev.meta_kind)
                    merf_pkg::MK_SEQNUM: begin
                        if (!recording || seqnum_seen) return merf_pkg::VD_DISCARD;
                        seqnum_seen = 1;
                        return merf_pkg::VD_FIRST_BEGIN;
                    end
                    merf_pkg::MK_OFFSET: begin
                        if (!recording || offset_seen) return merf_pkg::VD_DISCARD;
                        offset_seen = 1;
                        return merf_pkg::VD_FIRST_BEGIN;
                    end
                    merf_pkg::MK_TEMPO: begin
                        if (ev.meta_value == tempo_last) return merf_pkg::VD_DISCARD;
                        if (recording) tempo_cnt = bump(tempo_cnt);
                        tempo_last = ev.meta_value;
                        return merf_pkg::VD_FIRST_TRACK;
                    end
                    merf_pkg::MK_TIMESIG: begin
                        if (ev.meta_value == timesig_last) return merf_pkg::VD_DISCARD;
                        if (recording) timesig_cnt = bump(timesig_cnt);
                        timesig_last = ev.meta_value;
                        return merf_pkg::VD_FIRST_TRACK;
                    end
                    merf_pkg::MK_MARKER: begin
                        if (recording) marker_cnt = bump(marker_cnt);
                        return merf_pkg::VD_FIRST_TRACK;
                    end
                    merf_pkg::MK_NAME: begin
                        if (!recording || name_seen[t]) return merf_pkg::VD_DISCARD;
                        name_seen[t] = 1;
                        return merf_pkg::VD_TRACK_BEGIN;
                    end
                    merf_pkg::MK_END: begin
                        if (!recording || end_seen[t]) return merf_pkg::VD_DISCARD;
                        end_seen[t] = 1;
                        return merf_pkg::VD_TRACK_END;
                    end
                    default: return merf_pkg::VD_DISCARD;
                endcase
            end
            merf_pkg::EV_NOTE_ON: begin
                if (note_map[slot]) return merf_pkg::VD_DISCARD;
                if (recording) trk_notes[t] = bump(trk_notes[t]);
                note_map[slot] = 1;
                if (notes_on[ev.channel] < merf_pkg::NOTES_MAX) notes_on[ev.channel]++;
            end
            merf_pkg::EV_NOTE_OFF: begin
                if (!note_map[slot]) return merf_pkg::VD_DISCARD;
                note_map[slot] = 0;
                if (notes_on[ev.channel] > 0) notes_on[ev.channel]--;
            end
            merf_pkg::EV_CTRL: begin
                if (ev.data_first == merf_pkg::CTRL_SKIP_NUM
                    && ev.channel == merf_pkg::CTRL_SKIP_CH)
                    return merf_pkg::VD_DISCARD;
                if ({1'b0, ev.data_second} == ctrl_last[slot]) return merf_pkg::VD_DISCARD;
                ctrl_last[slot] = {1'b0, ev.data_second};
            end
            merf_pkg::EV_PROG: begin
                if ({1'b0, ev.data_first} == prog_last[ev.channel])
                    return merf_pkg::VD_DISCARD;
                prog_last[ev.channel] = {1'b0, ev.data_first};
            end
            merf_pkg::EV_CHPRES, merf_pkg::EV_KEYPRES, merf_pkg::EV_BEND: ;
            merf_pkg::EV_SYSEX_F0, merf_pkg::EV_SYSEX_F7: return merf_pkg::VD_KEEP;
            default: return merf_pkg::VD_DISCARD;
        endcase
        if (recording) begin
            trk_events[t] = bump(trk_events[t]);
            trk_chans[t] = trk_chans[t] | (16'd1 << ev.channel);
            chans_all = chans_all | trk_chans[t];
        end
        return merf_pkg::VD_KEEP;
    endfunction

    function automatic merf_pkg::out_t predict_result(merf_pkg::in_t ev);
        merf_pkg::out_t r;
        bit ok;
        ok = ev.track <= NTRK - 1;
        r.verdict = judge_event(ev);
        r.track_event_count = ok ? trk_events[ev.track] : '0;
        r.track_note_count = ok ? trk_notes[ev.track] : '0;
        r.track_channel_mask = ok ? trk_chans[ev.track] : '0;
        r.overall_channel_mask = chans_all;
        r.tempo_change_count = tempo_cnt;
        r.timesig_change_count = timesig_cnt;
        r.marker_total = marker_cnt;
        r.last_tempo_value = tempo_last;
        r.last_timesig_value = timesig_last;
        r.notes_sounding = notes_on[ev.channel];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("tb: mismatch %s got %0h want %0h (result %0d)", what, got, want, checked);
    endtask

    // send one request; the sender idles in bursts and leaves valid high
    // between requests of one burst
    int burst_left = 0;
    task automatic send_event(merf_pkg::in_t ev);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_data <= ev;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        verdict_queue.push_back(predict_result(ev));
        sent++;
        @(negedge aclk);
    endtask

    // receiver stall pattern plus one long hold-off
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_ready <= 1'b0;
        end else if (stall_en) begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            merf_pkg::out_t w;
            if (verdict_queue.size() == 0) begin
                errors++;
                $display("tb: result with no request pending");
            end else begin
                w = verdict_queue.pop_front();
                if (m_data.verdict != w.verdict)
                    report("verdict", 32'(m_data.verdict), 32'(w.verdict));
                if (m_data.track_event_count != w.track_event_count)
                    report("track_event_count", m_data.track_event_count, w.track_event_count);
                if (m_data.track_note_count != w.track_note_count)
                    report("track_note_count", m_data.track_note_count, w.track_note_count);
                if (m_data.track_channel_mask != w.track_channel_mask)
                    report("track_channel_mask", 32'(m_data.track_channel_mask),
                           32'(w.track_channel_mask));
                if (m_data.overall_channel_mask != w.overall_channel_mask)
                    report("overall_channel_mask", 32'(m_data.overall_channel_mask),
                           32'(w.overall_channel_mask));
                if (m_data.tempo_change_count != w.tempo_change_count)
                    report("tempo_change_count", m_data.tempo_change_count, w.tempo_change_count);
                if (m_data.timesig_change_count != w.timesig_change_count)
                    report("timesig_change_count", m_data.timesig_change_count,
                           w.timesig_change_count);
                if (m_data.marker_total != w.marker_total)
                    report("marker_total", m_data.marker_total, w.marker_total);
                if (m_data.last_tempo_value != w.last_tempo_value)
                    report("last_tempo_value", m_data.last_tempo_value, w.last_tempo_value);
                if (m_data.last_timesig_value != w.last_timesig_value)
                    report("last_timesig_value", m_data.last_timesig_value, w.last_timesig_value);
                if (m_data.notes_sounding != w.notes_sounding)
                    report("notes_sounding", 32'(m_data.notes_sounding), 32'(w.notes_sounding));
            end
            checked++;
        end
    end

    function automatic merf_pkg::in_t make_event(bit ok, int trk, merf_pkg::event_kind_t k,
                                                 merf_pkg::meta_kind_t mk, int ch, int d1,
                                                 int d2, logic [31:0] mv);
        merf_pkg::in_t ev;
        ev.event_ok = ok;
        ev.track = 16'(trk);
        ev.event_kind = k;
        ev.meta_kind = mk;
        ev.channel = 4'(ch);
        ev.data_first = 7'(d1);
        ev.data_second = 7'(d2);
        ev.meta_value = mv;
        return ev;
    endfunction

    task automatic drain();
        s_valid <= 1'b0;
        while (verdict_queue.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_recording(bit en);
        drain();
        cfg_wr_data <= en;
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        recording = en;
    endtask

    // small pools so repeats, note pairs and track flags get exercised
    function automatic merf_pkg::in_t random_event();
        merf_pkg::in_t ev;
        int r;
        ev = merf_pkg::in_t'(($bits(merf_pkg::in_t))'({$urandom(), $urandom(), $urandom()}));
        ev.event_ok = ($urandom_range(0, 15) != 0);
        r = $urandom_range(0, 19);
        ev.track = (r == 0) ? 16'($urandom())
                 : (r == 1 ? 16'hFFFF : 16'($urandom_range(0, 7)));
        r = $urandom_range(0, 19);
        if (r < 5) ev.event_kind = merf_pkg::EV_NOTE_ON;
        else if (r < 10) ev.event_kind = merf_pkg::EV_NOTE_OFF;
        else if (r < 12) ev.event_kind = merf_pkg::EV_CTRL;
        else if (r < 13) ev.event_kind = merf_pkg::EV_PROG;
        else if (r < 16) ev.event_kind = merf_pkg::EV_META;
        else ev.event_kind = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 3) != 0) begin
            ev.channel = ($urandom_range(0, 3) == 0) ? merf_pkg::CTRL_SKIP_CH
                       : 4'($urandom_range(0, 3));
            ev.data_first = ($urandom_range(0, 3) == 0) ? merf_pkg::CTRL_SKIP_NUM
                          : 7'($urandom_range(60, 63));
            ev.data_second = 7'($urandom_range(0, 2));
            ev.meta_value = 32'($urandom_range(0, 3));
        end
        return ev;
    endfunction

    task automatic test_directed();
        send_event(make_event(0, 0, merf_pkg::EV_NOTE_ON, merf_pkg::MK_SEQNUM, 0, 60, 0, 0));
        send_event(make_event(1, 64, merf_pkg::EV_NOTE_ON, merf_pkg::MK_SEQNUM, 0, 60, 0, 0));
        send_event(make_event(1, 16'hFFFF, merf_pkg::EV_META, merf_pkg::MK_SEQNUM,
                              15, 127, 127, '1));
        send_event(make_event(1, 0, merf_pkg::EV_META, merf_pkg::MK_SEQNUM, 0, 0, 0, 0));
        send_event(make_event(1, 63, merf_pkg::EV_META, merf_pkg::MK_SEQNUM, 0, 0, 0, 0));
        send_event(make_event(1, 63, merf_pkg::EV_META, merf_pkg::MK_OFFSET, 0, 0, 0, 0));
        send_event(make_event(1, 1, merf_pkg::EV_META, merf_pkg::MK_TEMPO, 0, 0, 0, 0));
        send_event(make_event(1, 1, merf_pkg::EV_META, merf_pkg::MK_TEMPO, 0, 0, 0, '1));
        send_event(make_event(1, 1, merf_pkg::EV_META, merf_pkg::MK_TIMESIG, 0, 0, 0, 0));
        send_event(make_event(1, 1, merf_pkg::EV_META, merf_pkg::MK_TIMESIG,
                              0, 0, 0, 32'h0404_1808));
        send_event(make_event(1, 1, merf_pkg::EV_META, merf_pkg::MK_MARKER, 0, 0, 0, 0));
        send_event(make_event(1, 63, merf_pkg::EV_META, merf_pkg::MK_NAME, 0, 0, 0, 0));
        send_event(make_event(1, 63, merf_pkg::EV_META, merf_pkg::MK_NAME, 0, 0, 0, 0));
        send_event(make_event(1, 63, merf_pkg::EV_META, merf_pkg::MK_END, 0, 0, 0, 0));
        send_event(make_event(1, 63, merf_pkg::EV_META, merf_pkg::MK_OTHER, 0, 0, 0, 0));
        send_event(make_event(1, 2, merf_pkg::EV_NOTE_ON, merf_pkg::MK_OTHER, 15, 127, 0, 0));
        send_event(make_event(1, 2, merf_pkg::EV_NOTE_ON, merf_pkg::MK_OTHER, 15, 127, 0, 0));
        send_event(make_event(1, 2, merf_pkg::EV_NOTE_OFF, merf_pkg::MK_OTHER, 15, 127, 0, 0));
        send_event(make_event(1, 2, merf_pkg::EV_NOTE_OFF, merf_pkg::MK_OTHER, 15, 127, 0, 0));
        send_event(make_event(1, 2, merf_pkg::EV_CTRL, merf_pkg::MK_OTHER, 9, 7'h54, 5, 0));
        send_event(make_event(1, 2, merf_pkg::EV_CTRL, merf_pkg::MK_OTHER, 0, 7, 127, 0));
        send_event(make_event(1, 2, merf_pkg::EV_CTRL, merf_pkg::MK_OTHER, 0, 7, 127, 0));
        send_event(make_event(1, 2, merf_pkg::EV_PROG, merf_pkg::MK_OTHER, 3, 0, 0, 0));
        send_event(make_event(1, 2, merf_pkg::EV_BEND, merf_pkg::MK_OTHER, 4, 0, 0, 0));
        send_event(make_event(1, 2, merf_pkg::EV_SYSEX_F7, merf_pkg::MK_OTHER, 4, 0, 0, 0));
        send_event(make_event(1, 2, merf_pkg::event_kind_t'(4'd15), merf_pkg::MK_OTHER,
                              4, 0, 0, 0));
    endtask

    task automatic test_random(int n);
        repeat (n) send_event(random_event());
    endtask

    // receiver holds off while requests keep coming, so input must stall
    task automatic test_backpressure();
        hold_cycles = 200;
        repeat (20) send_event(random_event());
    endtask

    task automatic test_locked();
        set_recording(0);
        send_event(make_event(1, 5, merf_pkg::EV_META, merf_pkg::MK_NAME, 0, 0, 0, 0));
        send_event(make_event(1, 5, merf_pkg::EV_META, merf_pkg::MK_SEQNUM, 0, 0, 0, 0));
        send_event(make_event(1, 5, merf_pkg::EV_META, merf_pkg::MK_TEMPO,
                              0, 0, 0, 32'h0007_A120));
        test_random(200);
        set_recording(1);
    endtask

    initial begin
        clear_model();
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(300);
        test_backpressure();
        test_locked();
        stall_en = 1'b0;
        test_random(150);
        stall_en = 1'b1;
        test_random(250);
        drain();
        $display("tb: %0d events sent, %0d results checked, recording on and off,", sent, checked);
        $display("tb: with long receiver back-pressure and random idling");
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
